// ===== src/rmh_pkg.sv =====
// Shared constants, command codes and control/status structs for the running median block.
`default_nettype none
package rmh_pkg;
  localparam int SAMPLE_W   = 32;
  localparam int MED_W      = SAMPLE_W + 1;
  localparam int HEAP_DEPTH = 512;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int SIZE_W     = ADDR_W + 1;
  localparam int HELD_W     = 10;
  localparam int FULL_COUNT = 2 * HEAP_DEPTH - 1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH_ROOT,
    OP_PUSH_READ,
    OP_PUSH_MOVE,
    OP_PUSH_PLACE,
    OP_POP_START,
    OP_POP_LAST,
    OP_POP_READ_C,
    OP_POP_TAKE_C1,
    OP_POP_TAKE_C2,
    OP_POP_MOVE,
    OP_POP_PLACE,
    OP_SWITCH,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic i_zero;
    logic v_above_rd;
    logic moved;
    logic bal_needed;
    logic child_ge_n;
    logic child1_lt_n;
    logic best_above_last;
  } status_t;
endpackage
`default_nettype wire

// ===== src/running_median_two_heaps.sv =====
// Top level of the two-heap running median block.
// Each transfer on the input carries one signed 32-bit sample; each produces
// exactly one result transfer with twice the running median (33 bits, signed,
// so half values stay exact), the number of samples held, and a flag that is
// set when the sample was dropped because 1023 samples are already held.
// The lower half lives in a max-heap and the upper half in a min-heap, each a
// 512-entry RAM with one write and one registered read port. A dropped sample
// goes straight to its result. Otherwise the insertion sift-up reads the parent
// and compares on each heap level; if the heaps are then out of balance, a pop
// takes the larger heap's top, reads its last entry and on each level reads up
// to two children before the move, and the moved top is pushed into the other
// heap with a sift-up that again reads and compares on each level. Items are
// handled one at a time; a finished result waits in its output register while
// the block takes the next sample. Heap contents need no clearing after reset,
// so the block is ready as soon as reset is released.
`default_nettype none
module running_median_two_heaps import rmh_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [MED_W-1:0]         median_doubled,
  output logic        [HELD_W-1:0]        held_count,
  output logic                            full_reject
);
  cmd_t    cmd;
  status_t status;

  // Sequence the insert, the optional top move and the result transfer.
  rmh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .status(status), .cmd(cmd),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall)
  );

  // Hold both heaps, their sizes and roots, and the result register.
  rmh_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .sample(sample),
    .median_doubled(median_doubled), .held_count(held_count), .full_reject(full_reject)
  );
endmodule
`default_nettype wire

// ===== src/rmh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/rmh_datapath.sv =====
// Heap storage, sizes, cached tops, working registers and result register.
`default_nettype none
module rmh_datapath import rmh_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cmd_t                       cmd,
  output status_t                         status,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic signed [MED_W-1:0]         median_doubled,
  output logic        [HELD_W-1:0]        held_count,
  output logic                            full_reject
);
  logic                       side;  // 1: lower (max) heap, 0: upper (min) heap
  logic signed [SAMPLE_W-1:0] v, t, last, best, ltop, utop;
  logic [ADDR_W-1:0]          i, bidx;
  logic [SIZE_W-1:0]          lsize, usize;
  logic                       moved, reject;

  logic [SAMPLE_W-1:0]        lrd, urd;
  logic signed [SAMPLE_W-1:0] rd, wdata;
  logic [ADDR_W-1:0]          raddr, parent;
  logic                       wr;
  logic [SIZE_W-1:0]          cur_size, oth_size, pop_size;
  logic [SIZE_W:0]            held, child, child1;
  logic                       go_lower, bal_lower, bal_upper;

  function automatic logic above(input logic signed [SAMPLE_W-1:0] a,
                                 input logic signed [SAMPLE_W-1:0] b,
                                 input logic is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  assign rd        = $signed(side ? lrd : urd);
  assign cur_size  = side ? lsize : usize;
  assign oth_size  = side ? usize : lsize;
  assign held      = {1'b0, lsize} + {1'b0, usize};
  assign parent    = (i - ADDR_W'(1)) >> 1;
  assign child     = {1'b0, i, 1'b1};
  assign child1    = child + (SIZE_W+1)'(1);
  assign go_lower  = (lsize == '0) || (sample <= ltop);
  assign bal_lower = (lsize == usize + SIZE_W'(2));
  assign bal_upper = (usize == lsize + SIZE_W'(2));
  assign pop_size  = (bal_lower ? lsize : usize) - SIZE_W'(1);

  always_comb begin
    status.full            = (held >= (SIZE_W+1)'(FULL_COUNT));
    status.i_zero          = (i == '0);
    status.v_above_rd      = above(v, rd, side);
    status.moved           = moved;
    status.bal_needed      = bal_lower || bal_upper;
    status.child_ge_n      = (child >= {1'b0, cur_size});
    status.child1_lt_n     = (child1 < {1'b0, cur_size});
    status.best_above_last = above(best, last, side);
  end

  always_comb begin
    wr    = 1'b0;
    wdata = v;
    raddr = parent;
    unique case (cmd.op)
      OP_PUSH_ROOT, OP_PUSH_PLACE: wr = 1'b1;
      OP_PUSH_MOVE: begin
        wr    = 1'b1;
        wdata = rd;
      end
      OP_POP_START:   raddr = pop_size[ADDR_W-1:0];
      OP_POP_READ_C:  raddr = child[ADDR_W-1:0];
      OP_POP_TAKE_C1: raddr = child1[ADDR_W-1:0];
      OP_POP_MOVE: begin
        wr    = 1'b1;
        wdata = best;
      end
      OP_POP_PLACE: begin
        wr    = 1'b1;
        wdata = last;
      end
      default: ;
    endcase
  end

  rmh_ram #(.WIDTH(SAMPLE_W), .DEPTH(HEAP_DEPTH)) u_lower (
    .clk(clk), .we(wr && side), .waddr(i), .wdata(wdata), .raddr(raddr), .rdata(lrd)
  );
  rmh_ram #(.WIDTH(SAMPLE_W), .DEPTH(HEAP_DEPTH)) u_upper (
    .clk(clk), .we(wr && !side), .waddr(i), .wdata(wdata), .raddr(raddr), .rdata(urd)
  );

  // Keep copies of both roots so the median needs no memory read.
  always_ff @(posedge clk) begin
    if (wr && (i == '0)) begin
      if (side) begin
        ltop <= wdata;
      end else begin
        utop <= wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lsize <= '0;
      usize <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          if (!status.full) begin
            if (go_lower) begin
              lsize <= lsize + SIZE_W'(1);
            end else begin
              usize <= usize + SIZE_W'(1);
            end
          end
        end
        OP_POP_START: begin
          if (bal_lower) begin
            lsize <= lsize - SIZE_W'(1);
          end else begin
            usize <= usize - SIZE_W'(1);
          end
        end
        OP_SWITCH: begin
          if (side) begin
            usize <= usize + SIZE_W'(1);
          end else begin
            lsize <= lsize + SIZE_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        v      <= sample;
        side   <= go_lower;
        i      <= (go_lower ? lsize[ADDR_W-1:0] : usize[ADDR_W-1:0]);
        moved  <= 1'b0;
        reject <= status.full;
      end
      OP_PUSH_MOVE: i <= parent;
      OP_POP_START: begin
        side <= bal_lower;
        t    <= bal_lower ? ltop : utop;
        i    <= '0;
      end
      OP_POP_LAST: last <= rd;
      OP_POP_TAKE_C1: begin
        best <= rd;
        bidx <= child[ADDR_W-1:0];
      end
      OP_POP_TAKE_C2: begin
        if (above(rd, best, side)) begin
          best <= rd;
          bidx <= child1[ADDR_W-1:0];
        end
      end
      OP_POP_MOVE: i <= bidx;
      OP_SWITCH: begin
        side  <= !side;
        v     <= t;
        i     <= oth_size[ADDR_W-1:0];
        moved <= 1'b1;
      end
      OP_OUT: begin
        if (lsize == usize) begin
          median_doubled <= MED_W'(ltop) + MED_W'(utop);
        end else if (lsize > usize) begin
          median_doubled <= MED_W'(ltop) + MED_W'(ltop);
        end else begin
          median_doubled <= MED_W'(utop) + MED_W'(utop);
        end
        held_count  <= held[HELD_W-1:0];
        full_reject <= reject;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= (SIZE_W+1)'(FULL_COUNT)) else $error("held count beyond capacity");
  a_balanced_at_load: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_LOAD |-> (lsize <= usize + SIZE_W'(1)) && (usize <= lsize + SIZE_W'(1)))
    else $error("heaps out of balance at new sample");
  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD) && status.full |=> $stable(lsize) && $stable(usize))
    else $error("rejected sample changed heap sizes");
`endif
endmodule
`default_nettype wire

// ===== src/rmh_ctrl.sv =====
// Sequencer for insert, rebalance and result handoff.
`default_nettype none
module rmh_ctrl import rmh_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire status_t status,
  output cmd_t         cmd,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall
);
  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_PUSH_CHK = 11'b00000000010,
    S_PUSH_CMP = 11'b00000000100,
    S_BAL      = 11'b00000001000,
    S_POP_LAST = 11'b00000010000,
    S_POP_CHK  = 11'b00000100000,
    S_POP_C1   = 11'b00001000000,
    S_POP_C2   = 11'b00010000000,
    S_POP_CMP  = 11'b00100000000,
    S_POP_END  = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = status.full ? S_DONE : S_PUSH_CHK;
        end
      end
      S_PUSH_CHK: begin
        if (status.i_zero) begin
          cmd.op     = OP_PUSH_ROOT;
          state_next = S_BAL;
        end else begin
          cmd.op     = OP_PUSH_READ;
          state_next = S_PUSH_CMP;
        end
      end
      S_PUSH_CMP: begin
        if (status.v_above_rd) begin
          cmd.op     = OP_PUSH_MOVE;
          state_next = S_PUSH_CHK;
        end else begin
          cmd.op     = OP_PUSH_PLACE;
          state_next = S_BAL;
        end
      end
      S_BAL: begin
        if (!status.moved && status.bal_needed) begin
          cmd.op     = OP_POP_START;
          state_next = S_POP_LAST;
        end else begin
          state_next = S_DONE;
        end
      end
      S_POP_LAST: begin
        cmd.op     = OP_POP_LAST;
        state_next = S_POP_CHK;
      end
      S_POP_CHK: begin
        if (status.child_ge_n) begin
          cmd.op     = OP_POP_PLACE;
          state_next = S_POP_END;
        end else begin
          cmd.op     = OP_POP_READ_C;
          state_next = S_POP_C1;
        end
      end
      S_POP_C1: begin
        cmd.op     = OP_POP_TAKE_C1;
        state_next = status.child1_lt_n ? S_POP_C2 : S_POP_CMP;
      end
      S_POP_C2: begin
        cmd.op     = OP_POP_TAKE_C2;
        state_next = S_POP_CMP;
      end
      S_POP_CMP: begin
        if (status.best_above_last) begin
          cmd.op     = OP_POP_MOVE;
          state_next = S_POP_CHK;
        end else begin
          cmd.op     = OP_POP_PLACE;
          state_next = S_POP_END;
        end
      end
      S_POP_END: begin
        cmd.op     = OP_SWITCH;
        state_next = S_PUSH_CHK;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_out_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT |-> out_free) else $error("result overwritten before transfer");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE) else $error("accepted item not started");
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && !out_free |=> state == S_DONE) else $error("result dropped");
`endif
endmodule
`default_nettype wire
